// ----- rtl/core/cbor_pkg.sv -----
//==============================================================================
// cbor_pkg
// Shared types and constants for the streaming CBOR decoder.
//==============================================================================
package cbor_pkg;

    localparam int MaxDepthDef     = 64;
    localparam int ConsumedBitsDef = 32;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_data;
        logic       end_of_buffer;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [63:0] argument;
        logic [7:0]  payload_byte;
        logic [6:0]  nest_level;
        logic        is_map_key;
        logic [2:0]  error_code;
        logic        item_complete;
        logic [31:0] byte_count;
    } t_out_item;

    typedef enum logic [1:0] {
        PH_HEAD    = 2'd0,
        PH_ARG     = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_DONE    = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_CLIMB = 2'd1,
        ST_SEND  = 2'd2
    } t_ctl_state;

    localparam logic [3:0] K_PAYLOAD = 4'd10;
    localparam logic [3:0] K_ERROR   = 4'd11;
    localparam logic [3:0] K_FALSE   = 4'd6;

    localparam logic [2:0] E_NONE      = 3'd0;
    localparam logic [2:0] E_TRUNC     = 3'd1;
    localparam logic [2:0] E_INDEF     = 3'd2;
    localparam logic [2:0] E_RESERVED  = 3'd3;
    localparam logic [2:0] E_INT_RANGE = 3'd4;
    localparam logic [2:0] E_TOO_DEEP  = 3'd5;
    localparam logic [2:0] E_TAG       = 3'd6;
    localparam logic [2:0] E_SIMPLE    = 3'd7;

    localparam logic [4:0] AI_ONE   = 5'd24;
    localparam logic [4:0] AI_EIGHT = 5'd27;
    localparam logic [4:0] AI_INDEF = 5'd31;
    localparam logic [4:0] AI_SIMPLE_LO = 5'd20;
    localparam logic [4:0] AI_SIMPLE_HI = 5'd23;

    // command from controller to the stack cells
    typedef enum logic [1:0] {
        SC_NONE = 2'd0,
        SC_PUSH = 2'd1,
        SC_STEP = 2'd2
    } t_stk_op;

    typedef struct packed {
        t_stk_op     op;
        logic        is_map;
        logic [63:0] count;
    } t_stk_cmd;

    // view of the top-of-stack cell
    typedef struct packed {
        logic        is_map;
        logic        awaiting;
        logic [63:0] count;
    } t_stk_top;

endpackage

// ----- rtl/core/cbor_cell.sv -----
//==============================================================================
// cbor_cell
// One stack level: child count and map key/value flags; shifts toward its
// neighbors on push and pop so the top of stack always sits in cell zero.
//==============================================================================
module cbor_cell
    import cbor_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_push,
    input  logic        i_pop,
    input  logic        i_step,
    input  t_stk_top    i_from_above,
    input  t_stk_top    i_from_below,
    output t_stk_top    o_val
);
    t_stk_top r_val, n_val;

    always_comb begin
        n_val = r_val;
        if (i_push) begin
            n_val = i_from_above;
        end else if (i_pop) begin
            n_val = i_from_below;
        end else if (i_step) begin
            // key done -> wait value; value or child done -> count down
            if (r_val.is_map && !r_val.awaiting) begin
                n_val.awaiting = 1'b1;
            end else begin
                n_val.awaiting = 1'b0;
                n_val.count    = r_val.count - 64'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;
endmodule

// ----- rtl/core/cbor_stack.sv -----
//==============================================================================
// cbor_stack
// Chain of stack cells; cell zero is the innermost open container.
//==============================================================================
module cbor_stack
    import cbor_pkg::*;
#(
    parameter int MAX_DEPTH = MaxDepthDef
) (
    input  logic     i_clk,
    input  t_stk_cmd i_cmd,
    input  logic     i_pop,
    output t_stk_top o_top
);
    t_stk_top w_val [MAX_DEPTH];
    t_stk_top w_new;

    always_comb begin
        w_new.is_map   = i_cmd.is_map;
        w_new.awaiting = 1'b0;
        w_new.count    = i_cmd.count;
    end

    for (genvar g = 0; g < MAX_DEPTH; g++) begin : g_cell
        t_stk_top w_above, w_below;
        if (g == 0) begin : g_first
            assign w_above = w_new;
        end else begin : g_mid
            assign w_above = w_val[g-1];
        end
        if (g == MAX_DEPTH - 1) begin : g_last
            assign w_below = w_val[g];
        end else begin : g_inner
            assign w_below = w_val[g+1];
        end
        cbor_cell u_cell (
            .i_clk        (i_clk),
            .i_push       (i_cmd.op == SC_PUSH),
            .i_pop        (i_pop),
            .i_step       ((i_cmd.op == SC_STEP) && (g == 0)),
            .i_from_above (w_above),
            .i_from_below (w_below),
            .o_val        (w_val[g])
        );
    end

    assign o_top = w_val[0];
endmodule

// ----- rtl/core/cbor_stream_decoder.sv -----
//==============================================================================
// cbor_stream_decoder
// Byte-serial decoder for one definite-length CBOR item, with a shifting
// chain of stack cells for open arrays and maps.
//==============================================================================
//  channel   direction  payload      handshake
//  input     in         t_in_item    i_in_valid / o_in_stall
//  output    out        t_out_item   o_out_valid / i_out_stall
//
//  a byte is decoded in the cycle it is taken; each finished container it
//  closes adds a pass of the climb loop through the cell chain, then the
//  send state follows when a token results.
//  reset clears phase, depth and counters; cell contents need no reset.
//  input is stalled while a token waits or the climb is running.
//==============================================================================
module cbor_stream_decoder
    import cbor_pkg::*;
#(
    parameter int MAX_DEPTH     = MaxDepthDef,
    parameter int CONSUMED_BITS = ConsumedBitsDef
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);
    localparam int DW = $clog2(MAX_DEPTH + 1);

    t_ctl_state r_st, n_st;
    t_phase     r_ph, n_ph;
    logic [2:0]  r_major, n_major;
    logic [63:0] r_acc, n_acc;
    logic [3:0]  r_argleft, n_argleft;
    logic [63:0] r_payleft, n_payleft;
    logic [DW-1:0] r_depth, n_depth;
    logic [CONSUMED_BITS-1:0] r_cnt, n_cnt;
    logic        r_eob, n_eob;
    t_out_item   r_out, n_out;
    logic        r_has_tok, n_has_tok;

    t_stk_cmd w_cmd;
    logic     w_pop;
    t_stk_top w_top;

    cbor_stack #(.MAX_DEPTH(MAX_DEPTH)) u_stack (
        .i_clk (i_clk),
        .i_cmd (w_cmd),
        .i_pop (w_pop),
        .o_top (w_top)
    );

    logic       w_acc;
    logic [7:0] w_b;
    logic [2:0] w_mj;
    logic [4:0] w_ai;
    logic [63:0] w_sh;
    logic [31:0] w_cnt_out;
    logic       w_key;

    assign o_in_stall  = (r_st != ST_IDLE);
    assign o_out_valid = (r_st == ST_SEND);
    assign o_out_data  = r_out;
    assign w_acc = i_in_valid && !o_in_stall;
    assign w_b   = i_in_data.data_byte;
    assign w_mj  = w_b[7:5];
    assign w_ai  = w_b[4:0];
    assign w_sh  = {r_acc[55:0], w_b};
    assign w_key = (r_depth != '0) && w_top.is_map && !w_top.awaiting;

    // counter saturates at its own width, the token shows its low 32 bits
    assign w_cnt_out = 32'(n_cnt);

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: begin
                if (w_cmd.op == SC_STEP && w_top.count == 64'd1 && !(w_top.is_map
                    && !w_top.awaiting)) begin
                    n_st = ST_CLIMB;
                end else if (n_has_tok) begin
                    n_st = ST_SEND;
                end
            end
            ST_CLIMB: begin
                if (w_cmd.op == SC_STEP && w_top.count == 64'd1 && !(w_top.is_map
                    && !w_top.awaiting)) begin
                    n_st = ST_CLIMB;
                end else if (n_has_tok) begin
                    n_st = ST_SEND;
                end else begin
                    n_st = ST_IDLE;
                end
            end
            ST_SEND: begin
                if (!i_out_stall) n_st = ST_IDLE;
            end
            default: n_st = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        logic       climb;
        logic       fail;
        logic [2:0] ecode;
        logic       fin;
        logic [2:0] fmaj;
        logic [63:0] farg;
        logic       tok;
        n_ph = r_ph; n_major = r_major; n_acc = r_acc; n_argleft = r_argleft;
        n_payleft = r_payleft; n_depth = r_depth; n_cnt = r_cnt; n_eob = r_eob;
        n_out = r_out; n_has_tok = r_has_tok;
        w_cmd = '0; w_cmd.op = SC_NONE; w_pop = 1'b0;
        climb = 1'b0; fail = 1'b0; ecode = E_NONE; fin = 1'b0;
        fmaj = r_major; farg = '0; tok = 1'b0;

        if (r_st == ST_IDLE && w_acc && r_ph != PH_DONE) begin
            n_has_tok = 1'b0;
            n_eob = i_in_data.end_of_buffer;
            if (i_in_data.has_data) begin
                if (r_cnt != '1) n_cnt = r_cnt + 1'b1;
                n_out.byte_count     = w_cnt_out;
                n_out.nest_level     = 7'(r_depth);
                n_out.is_map_key     = w_key;
                n_out.argument       = '0;
                n_out.payload_byte   = '0;
                n_out.error_code     = E_NONE;
                n_out.item_complete  = 1'b0;
                case (r_ph)
                    PH_HEAD: begin
                        if (w_mj == 3'd6) begin
                            fail = 1'b1; ecode = E_TAG;
                        end else if (w_mj == 3'd7) begin
                            if (w_ai inside {[AI_SIMPLE_LO:AI_SIMPLE_HI]}) begin
                                tok = 1'b1; climb = 1'b1;
                                n_out.token_kind = K_FALSE + 4'(w_ai - AI_SIMPLE_LO);
                                n_out.argument   = 64'(w_ai);
                            end else begin
                                fail = 1'b1; ecode = E_SIMPLE;
                            end
                        end else if (w_ai < AI_ONE) begin
                            fin = 1'b1; fmaj = w_mj; farg = 64'(w_ai);
                        end else if (w_ai <= AI_EIGHT) begin
                            n_major = w_mj; n_acc = '0;
                            n_argleft = 4'd1 << (w_ai - AI_ONE);
                            n_ph = PH_ARG;
                        end else begin
                            fail = 1'b1;
                            ecode = (w_ai == AI_INDEF) ? E_INDEF : E_RESERVED;
                        end
                    end
                    PH_ARG: begin
                        n_acc = w_sh;
                        n_argleft = r_argleft - 4'd1;
                        if (r_argleft <= 4'd1) begin
                            fin = 1'b1; fmaj = r_major; farg = w_sh;
                        end
                    end
                    default: begin
                        tok = 1'b1;
                        n_out.token_kind   = K_PAYLOAD;
                        n_out.payload_byte = w_b;
                        n_payleft = r_payleft - 64'd1;
                        if (r_payleft <= 64'd1) climb = 1'b1;
                    end
                endcase
                if (fin) begin
                    tok = 1'b1;
                    n_out.token_kind = {1'b0, fmaj};
                    n_out.argument   = farg;
                    if (fmaj <= 3'd1) begin
                        if (farg[63]) begin
                            tok = 1'b0; fail = 1'b1; ecode = E_INT_RANGE;
                        end else climb = 1'b1;
                    end else if (farg == '0) begin
                        climb = 1'b1;
                    end else if (fmaj <= 3'd3) begin
                        n_payleft = farg; n_ph = PH_PAYLOAD;
                    end else if (32'(r_depth) >= MAX_DEPTH) begin
                        tok = 1'b0; fail = 1'b1; ecode = E_TOO_DEEP;
                    end else begin
                        w_cmd.op = SC_PUSH; w_cmd.is_map = (fmaj == 3'd5);
                        w_cmd.count = farg;
                        n_depth = r_depth + 1'b1; n_ph = PH_HEAD;
                    end
                end
                if (climb) begin
                    n_ph = PH_HEAD;
                    if (r_depth == '0) begin
                        n_ph = PH_DONE; n_out.item_complete = 1'b1;
                    end else begin
                        w_cmd.op = SC_STEP;
                        if (w_top.count == 64'd1 && !(w_top.is_map && !w_top.awaiting))
                        begin
                            w_pop = 1'b1; n_depth = r_depth - 1'b1;
                        end
                    end
                end
                if (tok) n_has_tok = 1'b1;
                if (fail) begin
                    n_has_tok = 1'b1; n_ph = PH_DONE;
                    n_out.token_kind = K_ERROR; n_out.argument = '0;
                    n_out.payload_byte = '0; n_out.is_map_key = 1'b0;
                    n_out.error_code = ecode; n_out.item_complete = 1'b0;
                end
            end
            // truncation check when no climb is pending
            if (i_in_data.end_of_buffer && !fail && n_ph != PH_DONE && !w_pop) begin
                n_has_tok = 1'b1; n_ph = PH_DONE;
                n_out.token_kind = K_ERROR; n_out.argument = '0;
                n_out.payload_byte = '0; n_out.is_map_key = 1'b0;
                n_out.error_code = E_TRUNC; n_out.item_complete = 1'b0;
                n_out.nest_level = 7'(n_depth);
                n_out.byte_count = w_cnt_out;
            end
        end else if (r_st == ST_CLIMB) begin
            // continue closing finished containers
            if (r_depth == '0) begin
                n_ph = PH_DONE; n_out.item_complete = 1'b1;
            end else begin
                w_cmd.op = SC_STEP;
                if (w_top.count == 64'd1 && !(w_top.is_map && !w_top.awaiting)) begin
                    w_pop = 1'b1; n_depth = r_depth - 1'b1;
                end
            end
            if (r_eob && n_ph != PH_DONE && !w_pop) begin
                n_has_tok = 1'b1; n_ph = PH_DONE;
                n_out.token_kind = K_ERROR; n_out.argument = '0;
                n_out.payload_byte = '0; n_out.is_map_key = 1'b0;
                n_out.error_code = E_TRUNC; n_out.item_complete = 1'b0;
                n_out.nest_level = 7'(n_depth);
            end
        end else if (r_st == ST_SEND && !i_out_stall) begin
            n_has_tok = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_ph <= PH_HEAD; r_major <= '0; r_acc <= '0;
            r_argleft <= '0; r_payleft <= '0; r_depth <= '0; r_cnt <= '0;
            r_eob <= 1'b0; r_has_tok <= 1'b0;
        end else begin
            r_st <= n_st; r_ph <= n_ph; r_major <= n_major; r_acc <= n_acc;
            r_argleft <= n_argleft; r_payleft <= n_payleft; r_depth <= n_depth;
            r_cnt <= n_cnt; r_eob <= n_eob; r_has_tok <= n_has_tok;
        end
        r_out <= n_out;
    end
endmodule

// ----- rtl/core/cbor_checker.sv -----
//==============================================================================
// cbor_checker
// Port-level checks on the decoder's handshakes and tokens.
//==============================================================================
module cbor_checker
    import cbor_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);
    // a waiting token holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("token changed while stalled");

    // input is never taken while a token waits
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open with token pending");

    // error tokens carry a code, others none
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.token_kind == K_ERROR) ==
                         (o_out_data.error_code != E_NONE)))
        else $error("error code mismatch");

    // completion never comes with an error
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.item_complete |-> o_out_data.token_kind != K_ERROR)
        else $error("complete flag on error");
endmodule

bind cbor_stream_decoder cbor_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// ----- sim/cbor_stream_decoder_test.sv -----
//==============================================================================
// cbor_stream_decoder_test
// Streams one large CBOR array of mixed nested content into the decoder, with
// empty calls and random gaps on both sides, and checks every token against a
// cycle-free model of the decoder; the stream ends in a randomly chosen error
// or in normal completion.
//==============================================================================
module cbor_stream_decoder_test;
    import cbor_pkg::*;

    localparam int DEPTH_LIMIT = 64;
    localparam logic [2:0] MAJ_UINT   = 3'd0;
    localparam logic [2:0] MAJ_NINT   = 3'd1;
    localparam logic [2:0] MAJ_BSTR   = 3'd2;
    localparam logic [2:0] MAJ_TSTR   = 3'd3;
    localparam logic [2:0] MAJ_ARRAY  = 3'd4;
    localparam logic [2:0] MAJ_MAP    = 3'd5;
    localparam logic [2:0] MAJ_TAG    = 3'd6;
    localparam logic [2:0] MAJ_SIMPLE = 3'd7;
    localparam int END_NORMAL = 0;
    localparam int END_TRUNC  = 1;
    localparam int END_INDEF  = 2;
    localparam int END_RSVD   = 3;
    localparam int END_RANGE  = 4;
    localparam int END_DEEP   = 5;
    localparam int END_TAG    = 6;
    localparam int END_SIMPLE = 7;
    localparam int DRAIN_AT   = 300;
    localparam int HOLD_AT    = 150;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;

    cbor_stream_decoder i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // decoder model state
    t_phase      ph;
    logic [2:0]  hmaj;
    logic [63:0] acc;
    int          arg_left;
    logic [63:0] pay_left;
    logic [63:0] kids [0:DEPTH_LIMIT];
    bit          val_wait [0:DEPTH_LIMIT];
    bit          lvl_map [0:DEPTH_LIMIT];
    int          depth;
    longint unsigned nbytes;
    t_out_item   tok;
    bit          tok_v;

    t_out_item   tokens_due [$];
    t_in_item    byte_feed [$];
    logic [7:0]  gen [$];
    int          errors = 0;
    int          n_sent = 0;
    int          n_seen = 0;

    function automatic void emit(input logic [3:0] kind, input logic [63:0] arg,
                                 input logic [7:0] pay, input int lvl, input bit key,
                                 input logic [2:0] err, input bit done);
        tok.token_kind     = kind;
        tok.argument       = arg;
        tok.payload_byte   = pay;
        tok.nest_level     = lvl[6:0];
        tok.is_map_key     = key;
        tok.error_code     = err;
        tok.item_complete  = done;
        tok.byte_count     = (nbytes > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : nbytes[31:0];
        tok_v = 1'b1;
    endfunction

    function automatic void raise_err(input logic [2:0] code);
        emit(K_ERROR, 64'd0, 8'd0, depth, 1'b0, code, 1'b0);
        ph = PH_DONE;
    endfunction

    function automatic bit key_of(input int d);
        if (d == 0) return 1'b0;
        return lvl_map[d-1] && !val_wait[d-1];
    endfunction

    // item at current depth finished: close every container it fills
    function automatic bit climb();
        int d;
        int p;
        d = depth;
        while (1) begin
            if (d == 0) begin
                depth = 0;
                ph = PH_DONE;
                return 1'b1;
            end
            p = d - 1;
            if (lvl_map[p] && !val_wait[p]) begin
                val_wait[p] = 1'b1;
                break;
            end
            val_wait[p] = 1'b0;
            kids[p] = kids[p] - 1;
            if (kids[p] != 0) break;
            d = p;
        end
        depth = d;
        ph = PH_HEAD;
        return 1'b0;
    endfunction

    function automatic void head_done(input logic [2:0] major, input logic [63:0] arg);
        int d;
        bit key;
        bit done;
        d = depth;
        key = key_of(d);
        done = 1'b0;
        if (major <= MAJ_NINT) begin
            if (arg[63]) begin
                raise_err(E_INT_RANGE);
                return;
            end
            done = climb();
        end else if (major <= MAJ_TSTR) begin
            if (arg == 0) done = climb();
            else begin
                pay_left = arg;
                ph = PH_PAYLOAD;
            end
        end else begin
            if (arg == 0) done = climb();
            else begin
                if (d >= DEPTH_LIMIT) begin
                    raise_err(E_TOO_DEEP);
                    return;
                end
                kids[d] = arg;
                val_wait[d] = 1'b0;
                lvl_map[d] = (major == MAJ_MAP);
                depth = d + 1;
                ph = PH_HEAD;
            end
        end
        emit({1'b0, major}, arg, 8'd0, d, key, E_NONE, done);
    endfunction

    function automatic void take_byte(input logic [7:0] b);
        logic [2:0] major;
        logic [4:0] ai;
        int d;
        bit key;
        bit done;
        major = b[7:5];
        ai = b[4:0];
        d = depth;
        key = key_of(d);
        if (ph == PH_HEAD) begin
            if (major == MAJ_TAG) raise_err(E_TAG);
            else if (major == MAJ_SIMPLE) begin
                if (ai < AI_SIMPLE_LO || ai > AI_SIMPLE_HI) raise_err(E_SIMPLE);
                else begin
                    done = climb();
                    emit(K_FALSE + 4'(ai - AI_SIMPLE_LO), 64'(ai), 8'd0, d, key,
                         E_NONE, done);
                end
            end else if (ai < AI_ONE) head_done(major, 64'(ai));
            else if (ai <= AI_EIGHT) begin
                hmaj = major;
                acc = '0;
                arg_left = 1 << (ai - AI_ONE);
                ph = PH_ARG;
            end else raise_err(ai == AI_INDEF ? E_INDEF : E_RESERVED);
        end else if (ph == PH_ARG) begin
            acc = {acc[55:0], b};
            arg_left--;
            if (arg_left == 0) head_done(hmaj, acc);
        end else begin
            done = 1'b0;
            pay_left = pay_left - 1;
            if (pay_left == 0) done = climb();
            emit(K_PAYLOAD, 64'd0, b, d, key, E_NONE, done);
        end
    endfunction

    function automatic void decode_item(input t_in_item x);
        tok_v = 1'b0;
        if (ph == PH_DONE) return;
        if (x.has_data) begin
            nbytes++;
            take_byte(x.data_byte);
        end
        if (ph != PH_DONE && x.end_of_buffer) raise_err(E_TRUNC);
        if (tok_v) tokens_due.push_back(tok);
    endfunction

    // stream encoding helpers
    task automatic put_head(input logic [2:0] major, input logic [63:0] v);
        int need;
        int nb;
        need = (v < 24) ? 0 : (v < 64'h100) ? 1 : (v < 64'h1_0000) ? 2 :
               (v < 64'h1_0000_0000) ? 4 : 8;
        nb = need;
        if ($urandom_range(0, 3) == 0) begin
            nb = 1 << $urandom_range(0, 3);
            if (nb < need) nb = need;
        end
        case (nb)
            0: gen.push_back({major, v[4:0]});
            1: gen.push_back({major, AI_ONE});
            2: gen.push_back({major, AI_ONE + 5'd1});
            4: gen.push_back({major, AI_ONE + 5'd2});
            default: gen.push_back({major, AI_EIGHT});
        endcase
        for (int i = nb - 1; i >= 0; i--) gen.push_back(v[8*i +: 8]);
    endtask

    function automatic logic [63:0] rand_int();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0: v = v & 64'h1F;
            1: v = v & 64'hFF;
            2: v = v & 64'hFFFF;
            3: v = v & 64'hFFFF_FFFF;
            default: v[63] = 1'b0;
        endcase
        return v;
    endfunction

    task automatic put_string(input logic [2:0] major, input int len);
        put_head(major, 64'(len));
        for (int i = 0; i < len; i++) gen.push_back(8'($urandom));
    endtask

    task automatic put_value(input int lvl);
        int sel;
        int n;
        sel = $urandom_range(0, 9);
        if (lvl > 5 && sel >= 6) sel = 0;
        case (sel)
            0, 1: put_head(MAJ_UINT, rand_int());
            2: put_head(MAJ_NINT, rand_int());
            3: put_string(MAJ_BSTR, $urandom_range(0, 6));
            4: put_string(MAJ_TSTR, $urandom_range(0, 6));
            5: gen.push_back({MAJ_SIMPLE, 5'($urandom_range(20, 23))});
            6, 7: begin
                n = $urandom_range(0, 3);
                put_head(MAJ_ARRAY, 64'(n));
                for (int i = 0; i < n; i++) put_value(lvl + 1);
            end
            default: begin
                n = $urandom_range(0, 3);
                put_head(MAJ_MAP, 64'(n));
                for (int i = 0; i < 2 * n; i++) put_value(lvl + 1);
            end
        endcase
    endtask

    initial begin : build_stream
        logic [7:0] body [$];
        int children;
        int ending;
        t_in_item it;

        // directed children: argument extremes, every kind, deepest empty container
        put_head(MAJ_UINT, 64'd0);
        put_head(MAJ_UINT, 64'd23);
        gen.push_back({MAJ_UINT, AI_ONE}); gen.push_back(8'hFF);
        put_head(MAJ_UINT, 64'hFFFF);
        put_head(MAJ_UINT, 64'hFFFF_FFFF);
        put_head(MAJ_UINT, 64'h7FFF_FFFF_FFFF_FFFF);
        put_head(MAJ_NINT, 64'd0);
        put_head(MAJ_NINT, 64'h7FFF_FFFF_FFFF_FFFF);
        put_string(MAJ_BSTR, 0);
        gen.push_back({MAJ_TSTR, 5'd1}); gen.push_back(8'hFF);
        gen.push_back({MAJ_BSTR, 5'd1}); gen.push_back(8'h00);
        for (int i = 20; i <= 23; i++) gen.push_back({MAJ_SIMPLE, 5'(i)});
        put_head(MAJ_ARRAY, 64'd0);
        put_head(MAJ_MAP, 64'd0);
        gen.push_back({MAJ_MAP, 5'd1}); gen.push_back(8'h01); gen.push_back(8'h02);
        for (int i = 0; i < DEPTH_LIMIT - 1; i++) gen.push_back({MAJ_ARRAY, 5'd1});
        gen.push_back({MAJ_MAP, 5'd0});
        children = 19;
        while (gen.size() < 900) begin
            put_value(1);
            children++;
        end
        body = gen;
        gen = {};

        ending = $urandom_range(0, 8);
        if (ending > END_SIMPLE) ending = END_NORMAL;
        gen.push_back({MAJ_ARRAY, AI_EIGHT});
        for (int i = 7; i >= 0; i--)
            gen.push_back(8'((children + (ending != END_NORMAL)) >> (8 * i)));
        foreach (body[i]) gen.push_back(body[i]);
        case (ending)
            END_TRUNC: if ($urandom_range(0, 1)) begin
                gen.push_back({MAJ_UINT, AI_ONE + 5'd1}); gen.push_back(8'h12);
            end
            END_INDEF: gen.push_back({$urandom_range(0, 1) ? MAJ_ARRAY : MAJ_BSTR, AI_INDEF});
            END_RSVD: gen.push_back({3'($urandom_range(0, 5)), 5'($urandom_range(28, 30))});
            END_RANGE: begin
                gen.push_back({3'($urandom_range(0, 1)), AI_EIGHT});
                gen.push_back(8'h80 | 8'($urandom));
                for (int i = 0; i < 7; i++) gen.push_back(8'($urandom));
            end
            END_DEEP: for (int i = 0; i < DEPTH_LIMIT; i++) gen.push_back({MAJ_ARRAY, 5'd2});
            END_TAG: gen.push_back({MAJ_TAG, 5'($urandom)});
            END_SIMPLE: gen.push_back({MAJ_SIMPLE, $urandom_range(0, 1) ?
                                      5'($urandom_range(0, 19)) : 5'($urandom_range(24, 31))});
            default: ;
        endcase

        foreach (gen[i]) begin
            if ($urandom_range(0, 19) == 0) byte_feed.push_back('{8'($urandom), 1'b0, 1'b0});
            it.data_byte = gen[i];
            it.has_data = 1'b1;
            it.end_of_buffer = (i == gen.size() - 1) &&
                               (ending != END_TRUNC || $urandom_range(0, 1));
            byte_feed.push_back(it);
        end
        if (ending == END_TRUNC && !byte_feed[$].end_of_buffer)
            byte_feed.push_back('{8'($urandom), 1'b0, 1'b1});
        // bytes after the end are ignored by the decoder
        for (int i = 0; i < 20; i++)
            byte_feed.push_back('{8'($urandom), 1'($urandom), 1'($urandom)});

        ph = PH_HEAD; hmaj = '0; acc = '0; arg_left = 0; pay_left = '0;
        depth = 0; nbytes = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic int pick_gap(input bit burst);
        int r;
        if (burst) return 0;
        r = $urandom_range(0, 19);
        if (r < 12) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // byte driver
    int  send_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                decode_item(in_data);
                n_sent++;
            end
            if (in_valid && in_stall) begin
                // hold the stalled item
            end else if (send_gap > 0) begin
                send_gap--;
                in_valid <= 1'b0;
            end else if (n_sent == DRAIN_AT && tokens_due.size() != 0) begin
                in_valid <= 1'b0;
            end else if (byte_feed.size() != 0) begin
                in_data <= byte_feed.pop_front();
                in_valid <= 1'b1;
                send_gap = pick_gap((n_sent / 100) % 3 == 1);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    function automatic void check_token(input t_out_item got, input t_out_item want);
        if (got.token_kind != want.token_kind)
            $display("%0t kind exp %0d got %0d", $time, want.token_kind, got.token_kind);
        if (got.argument != want.argument)
            $display("%0t argument exp %h got %h", $time, want.argument, got.argument);
        if (got.payload_byte != want.payload_byte)
            $display("%0t payload exp %h got %h", $time, want.payload_byte, got.payload_byte);
        if (got.nest_level != want.nest_level)
            $display("%0t level exp %0d got %0d", $time, want.nest_level, got.nest_level);
        if (got.is_map_key != want.is_map_key)
            $display("%0t map key exp %0d got %0d", $time, want.is_map_key, got.is_map_key);
        if (got.error_code != want.error_code)
            $display("%0t error exp %0d got %0d", $time, want.error_code, got.error_code);
        if (got.item_complete != want.item_complete)
            $display("%0t complete exp %0d got %0d", $time, want.item_complete,
                     got.item_complete);
        if (got.byte_count != want.byte_count)
            $display("%0t consumed exp %0d got %0d", $time, want.byte_count,
                     got.byte_count);
        if (got != want) errors++;
    endfunction

    // token monitor
    int  stall_left = 0;
    bit  held_once = 1'b0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                n_seen++;
                if (tokens_due.size() == 0) begin
                    $display("%0t unexpected token exp none got %p", $time, out_data);
                    errors++;
                end else begin
                    check_token(out_data, tokens_due.pop_front());
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if (!held_once && n_seen >= HOLD_AT) begin
                // long hold-off so the decoder backs up onto its input
                held_once = 1'b1;
                stall_left = 400;
                out_stall <= 1'b1;
            end else begin
                stall_left = pick_gap((n_seen / 80) % 3 == 2);
                out_stall <= (stall_left > 0);
            end
        end
    end

    initial begin : finish_run
        @(posedge i_rst_n);
        while (byte_feed.size() != 0 || in_valid) @(posedge i_clk);
        while (tokens_due.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && tokens_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #20000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
